// File: design/mwuf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_pkg
// shared types, constants and mod-3 helpers for the union-find checker
// ----------------------------------------------------------------------------
package mwuf_pkg;

  localparam int unsigned MaxElements = 4096;
  localparam int unsigned SlotW       = $clog2(MaxElements);
  localparam int unsigned ElemW       = 13;
  localparam int unsigned CountW      = 32;
  localparam int unsigned OffW        = 2;
  localparam int unsigned PaddrW      = 3;
  localparam int unsigned PdataW      = 32;

  localparam logic [ElemW-1:0] ElemLimit    = ElemW'(MaxElements);
  localparam logic [ElemW-1:0] ElemCountRst = ElemW'(4096);

  // register index, taken from paddr above the byte lane bits
  localparam logic [PaddrW-3:0] RegElementCount = '0;

  localparam logic OpSame = 1'b0;
  localparam logic OpEats = 1'b1;

  typedef struct packed {
    logic [SlotW-1:0] parent;
    logic [OffW-1:0]  offset;
  } node_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic second;
    logic clear;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_bad;
    logic at_root;
    logic clear_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [OffW-1:0] add3(input logic [OffW-1:0] a,
                                           input logic [OffW-1:0] b);
    logic [OffW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[OffW-1:0];
  endfunction

  function automatic logic [OffW-1:0] sub3(input logic [OffW-1:0] a,
                                           input logic [OffW-1:0] b);
    logic [OffW:0] s;
    s = {1'b0, a} + 3'd3 - {1'b0, b};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[OffW-1:0];
  endfunction

endpackage

// File: design/mwuf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_if
// valid/ready channels for statements and results
// ----------------------------------------------------------------------------
interface mwuf_stmt_if;
  import mwuf_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [ElemW-1:0] first_element;
  logic [ElemW-1:0] second_element;

  modport source (output valid, op, first_element, second_element, input ready);
  modport sink   (input valid, op, first_element, second_element, output ready);
endinterface

interface mwuf_result_if;
  import mwuf_pkg::*;

  logic              valid;
  logic              ready;
  logic              statement_false;
  logic [CountW-1:0] false_count;

  modport source (output valid, statement_false, false_count, input ready);
  modport sink   (input valid, statement_false, false_count, output ready);
endinterface

// File: design/mwuf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_ctrl
// sequencer: clearing pass, accept, walk both chains, deliver result
// ----------------------------------------------------------------------------
module mwuf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mwuf_pkg::dp_status_t sts_i,
  output mwuf_pkg::ctrl_cmd_t  cmd_o
);
  import mwuf_pkg::*;

  typedef enum logic [4:0] {
    StClear  = 5'b00001,
    StIdle   = 5'b00010,
    StFindX  = 5'b00100,
    StFindY  = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.item_bad ? StFinish : StFindX;
        end
      end
      StFindX: begin
        cmd_o.walk = 1'b1;
        if (sts_i.at_root) begin
          state_d = StFindY;
        end
      end
      StFindY: begin
        cmd_o.walk   = 1'b1;
        cmd_o.second = 1'b1;
        if (sts_i.at_root) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/mwuf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_dpath
// forest memory, chain walker, link and check logic, result register
// ----------------------------------------------------------------------------
module mwuf_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mwuf_pkg::ctrl_cmd_t        cmd_i,
  output mwuf_pkg::dp_status_t       sts_o,
  input  logic [mwuf_pkg::ElemW-1:0] limit_i,
  input  logic                       op_i,
  input  logic [mwuf_pkg::ElemW-1:0] first_element_i,
  input  logic [mwuf_pkg::ElemW-1:0] second_element_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       statement_false_o,
  output logic [mwuf_pkg::CountW-1:0] false_count_o
);
  import mwuf_pkg::*;

  node_t mem [MaxElements];
  node_t rd_q;

  logic [SlotW-1:0]  cur_q, cur_d;
  logic [OffW-1:0]   sum_q, sum_d;
  logic [SlotW-1:0]  y_q;
  logic [SlotW-1:0]  rx_q;
  logic [OffW-1:0]   ox_q;
  logic              op_q;
  logic              bad_q, bad_d;
  logic [SlotW-1:0]  clr_q;
  logic [CountW-1:0] count_q;
  logic              out_valid_q;
  logic              out_false_q;

  logic [SlotW-1:0]  rd_addr;
  logic              wr_en;
  logic [SlotW-1:0]  wr_addr;
  node_t             wr_data;
  logic              at_root;
  logic              item_bad;
  logic [SlotW-1:0]  first_slot;
  logic [SlotW-1:0]  second_slot;

  assign first_slot  = SlotW'(first_element_i - ElemW'(1));
  assign second_slot = SlotW'(second_element_i - ElemW'(1));
  assign at_root     = (rd_q.parent == cur_q);

  always_comb begin
    item_bad = (first_element_i == '0) || (second_element_i == '0) ||
               (first_element_i > limit_i) || (second_element_i > limit_i) ||
               ((op_i == OpEats) && (first_element_i == second_element_i));
  end

  always_comb begin
    cur_d   = cur_q;
    sum_d   = sum_q;
    bad_d   = bad_q;
    rd_addr = cur_q;
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = '{parent: clr_q, offset: '0};
    if (cmd_i.clear) begin
      wr_en = 1'b1;
    end
    if (cmd_i.load) begin
      rd_addr = first_slot;
      cur_d   = first_slot;
      sum_d   = '0;
      bad_d   = item_bad;
    end else if (cmd_i.walk) begin
      if (!at_root) begin
        rd_addr = rd_q.parent;
        cur_d   = rd_q.parent;
        sum_d   = add3(sum_q, rd_q.offset);
      end else if (!cmd_i.second) begin
        rd_addr = y_q;
        cur_d   = y_q;
        sum_d   = '0;
      end else if (rx_q == cur_q) begin
        bad_d = (sub3(ox_q, sum_q) != OffW'(op_q));
      end else begin
        wr_en   = 1'b1;
        wr_addr = rx_q;
        wr_data = '{parent: cur_q, offset: add3(sub3(sum_q, ox_q), OffW'(op_q))};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    sum_q <= sum_d;
    if (cmd_i.load) begin
      op_q <= op_i;
      y_q  <= second_slot;
    end
    if (cmd_i.walk && at_root && !cmd_i.second) begin
      rx_q <= cur_q;
      ox_q <= sum_q;
    end
    if (cmd_i.finish) begin
      out_false_q <= bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      bad_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bad_q <= bad_d;
      if (cmd_i.clear) begin
        clr_q <= clr_q + SlotW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (bad_q && (count_q != '1)) begin
          count_q <= count_q + CountW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.item_bad   = item_bad;
  assign sts_o.at_root    = at_root;
  assign sts_o.clear_last = (clr_q == '1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign statement_false_o = out_false_q;
  assign false_count_o     = count_q;

endmodule

// File: design/mod3_weighted_union_find_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mod3_weighted_union_find_checker
// flow: a range or self-eat failure goes straight to the result; otherwise the
//   chains of x and y are walked to their roots in turn, before the result
// requests: one at a time; the next is taken once the last result is registered;
//   the single read port of the forest memory walks one parent link per cycle
// reset: a clearing pass over all 4096 slots sets every slot to point to itself,
//   with no request accepted; the register and false count reset at once
// ----------------------------------------------------------------------------
module mod3_weighted_union_find_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mwuf_stmt_if.sink                    stmt_i,
  mwuf_result_if.source                result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mwuf_pkg::PaddrW-1:0]  paddr,
  input  logic [mwuf_pkg::PdataW-1:0]  pwdata,
  output logic [mwuf_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);
  import mwuf_pkg::*;

  ctrl_cmd_t        cmd;
  dp_status_t       sts;
  logic [ElemW-1:0] elem_count_q;
  logic [ElemW-1:0] limit;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PaddrW-1:2] == RegElementCount);
  assign prdata  = reg_hit ? PdataW'(elem_count_q) : '0;
  assign limit   = (elem_count_q > ElemLimit) ? ElemLimit : elem_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_count_q <= ElemCountRst;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      elem_count_q <= pwdata[ElemW-1:0];
    end
  end

  mwuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (stmt_i.valid),
    .in_ready_o (stmt_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mwuf_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .limit_i           (limit),
    .op_i              (stmt_i.op),
    .first_element_i   (stmt_i.first_element),
    .second_element_i  (stmt_i.second_element),
    .out_valid_o       (result_o.valid),
    .out_ready_i       (result_o.ready),
    .statement_false_o (result_o.statement_false),
    .false_count_o     (result_o.false_count)
  );

endmodule
